FILE: hw/rtl/csv_tok_pkg.sv
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared types, codes and defaults of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  localparam int unsigned ROW_LIMIT_DEF    = 65536;
  localparam int unsigned COLUMN_LIMIT_DEF = 1024;
  localparam int unsigned OUTQ_DEPTH       = 4;

  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned ROWIX_W = 16;
  localparam int unsigned COLIX_W = 10;
  localparam int unsigned CFGIX_W = 8;

  localparam logic [CHAR_W-1:0] CR_CHAR           = 16'd13;
  localparam logic [CHAR_W-1:0] LF_CHAR           = 16'd10;
  localparam logic [CHAR_W-1:0] DQUOTE_CHAR       = 16'd34;
  localparam logic [CHAR_W-1:0] DEFAULT_DELIMITER = 16'd44;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [CFGIX_W-1:0] CFG_DELIMITER = 8'd0;
  localparam logic [CFGIX_W-1:0] CFG_QUOTE     = 8'd1;
  localparam logic [CFGIX_W-1:0] CFG_MERGE     = 8'd2;
  localparam logic [CFGIX_W-1:0] CFG_FIRST_ROW = 8'd3;

  typedef enum logic [2:0] {
    ST_START      = 3'd0,
    ST_QUOTED     = 3'd1,
    ST_MAYBE_END  = 3'd2,
    ST_AFTER_QUOTE = 3'd3,
    ST_UNQUOTED   = 3'd4
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_DISCARD   = 2'd2,
    KIND_SUMMARY   = 2'd3
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [CHAR_W-1:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic               valid;
    logic [CFGIX_W-1:0] index;
    logic [CHAR_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  ch;
    logic [ROWIX_W-1:0] row;
    logic [COLIX_W-1:0] col;
    logic               last;
  } res_t;

endpackage

FILE: hw/rtl/csv_tok_parser.sv
// ----------------------------------------------------------------------------
// CSV tokenizer parser
// Configuration registers, parse state machine and row/column counters.
// Produces up to two results for each accepted beat in the same cycle.
// ----------------------------------------------------------------------------
module csv_tok_parser #(
  parameter int unsigned ROW_LIMIT    = csv_tok_pkg::ROW_LIMIT_DEF,
  parameter int unsigned COLUMN_LIMIT = csv_tok_pkg::COLUMN_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csv_tok_pkg::in_beat_t      beat_i,
  input  csv_tok_pkg::cfg_wr_t       cfg_i,
  output csv_tok_pkg::res_t [1:0]    res_o,
  output logic [1:0]                 res_cnt_o
);

  localparam int unsigned RowW    = $clog2(ROW_LIMIT);
  localparam int unsigned ColW    = $clog2(COLUMN_LIMIT);
  localparam int unsigned CmpW    = (RowW > csv_tok_pkg::ROWIX_W) ? RowW : csv_tok_pkg::ROWIX_W;
  localparam int unsigned ColExtW = (ColW > csv_tok_pkg::COLIX_W) ? ColW : csv_tok_pkg::COLIX_W;
  localparam logic [RowW-1:0] RowMax = RowW'(ROW_LIMIT - 1);
  localparam logic [ColW-1:0] ColMax = ColW'(COLUMN_LIMIT - 1);

  // Configuration registers.
  logic [15:0] delim_q, quote_q, first_q;
  logic        merge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csv_tok_pkg::DEFAULT_DELIMITER;
      quote_q <= csv_tok_pkg::DQUOTE_CHAR;
      merge_q <= 1'b0;
      first_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        csv_tok_pkg::CFG_DELIMITER: delim_q <= cfg_i.data;
        csv_tok_pkg::CFG_QUOTE:     quote_q <= cfg_i.data;
        csv_tok_pkg::CFG_MERGE:     merge_q <= cfg_i.data[0];
        csv_tok_pkg::CFG_FIRST_ROW: first_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Parse state and counters.
  csv_tok_pkg::parse_state_e st_q, st_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d, hi_q, hi_d;
  logic            prev_q, prev_d, cr_q, cr_d, fne_q, fne_d;

  // Character classification.
  logic char_en, is_q, is_d, is_nl;
  assign char_en = beat_i.valid && (beat_i.op == csv_tok_pkg::OP_CHAR) &&
                   !((beat_i.ch == csv_tok_pkg::CR_CHAR) && !cr_q);
  assign is_q  = (quote_q != '0) && (beat_i.ch == quote_q);
  assign is_d  = (beat_i.ch == delim_q);
  assign is_nl = (beat_i.ch == csv_tok_pkg::LF_CHAR);

  // Actions chosen by the state machine for this character.
  logic act_append, act_close, act_discard, act_adv, adv_nl;

  always_comb begin
    st_d        = st_q;
    act_append  = 1'b0;
    act_close   = 1'b0;
    act_discard = 1'b0;
    act_adv     = 1'b0;
    adv_nl      = 1'b0;
    if (char_en) begin
      unique case (st_q)
        csv_tok_pkg::ST_QUOTED: begin
          if (is_q) begin
            st_d = csv_tok_pkg::ST_MAYBE_END;
          end else if (is_nl && (quote_q == '0)) begin
            act_close = 1'b1;
            adv_nl    = 1'b1;
          end else begin
            act_append = 1'b1;
          end
        end
        csv_tok_pkg::ST_MAYBE_END: begin
          if (is_q) begin
            act_append = 1'b1;
            st_d       = csv_tok_pkg::ST_QUOTED;
          end else if (is_d || is_nl) begin
            act_close = 1'b1;
            adv_nl    = is_nl;
          end else begin
            st_d = csv_tok_pkg::ST_AFTER_QUOTE;
          end
        end
        csv_tok_pkg::ST_AFTER_QUOTE: begin
          if (is_d || is_nl) begin
            act_close = 1'b1;
            adv_nl    = is_nl;
          end
        end
        csv_tok_pkg::ST_UNQUOTED: begin
          if (is_q) begin
            act_discard = 1'b1;
            st_d        = csv_tok_pkg::ST_QUOTED;
          end else if (is_d || is_nl) begin
            act_close = 1'b1;
            adv_nl    = is_nl;
          end else begin
            act_append = 1'b1;
          end
        end
        default: begin
          // Start of field: the delimiter wins over the newline here.
          if (is_q) begin
            st_d = csv_tok_pkg::ST_QUOTED;
          end else if (is_d) begin
            act_adv = 1'b1;
          end else if (is_nl) begin
            act_adv = 1'b1;
            adv_nl  = 1'b1;
          end else begin
            act_append = 1'b1;
            st_d       = csv_tok_pkg::ST_UNQUOTED;
          end
        end
      endcase
      if (act_close) begin
        act_adv = 1'b1;
        st_d    = csv_tok_pkg::ST_START;
      end
    end else if (beat_i.valid && (beat_i.op == csv_tok_pkg::OP_END)) begin
      st_d = csv_tok_pkg::ST_START;
    end
  end

  // Position fields of this beat's results; the summary uses the end row and highest column.
  logic [CmpW-1:0]    row_ext, first_ext, row_diff, end_ext, end_diff;
  logic [ColExtW-1:0] col_ext, hi_ext;
  logic [RowW-1:0]    row_inc, end_row;
  logic [ColW-1:0]    col_inc;
  logic               row_vis;

  assign row_inc   = (row_q == RowMax) ? row_q : row_q + 1'b1;
  assign col_inc   = (col_q == ColMax) ? col_q : col_q + 1'b1;
  assign row_ext   = CmpW'(row_q);
  assign first_ext = CmpW'(first_q);
  assign row_diff  = row_ext - first_ext;
  assign row_vis   = (row_ext >= first_ext);
  assign end_row   = fne_q ? row_inc : row_q;
  assign end_ext   = CmpW'(end_row);
  assign end_diff  = (end_ext >= first_ext) ? (end_ext - first_ext) : '0;
  assign col_ext   = ColExtW'(col_q);
  assign hi_ext    = ColExtW'(hi_q);

  // Counter updates and results.
  always_comb begin
    csv_tok_pkg::res_t rr;
    rr        = '0;
    rr.row    = row_diff[csv_tok_pkg::ROWIX_W-1:0];
    rr.col    = col_ext[csv_tok_pkg::COLIX_W-1:0];
    rr.last   = 1'b1;
    res_o     = '0;
    res_cnt_o = 2'd0;
    row_d     = row_q;
    col_d     = col_q;
    hi_d      = hi_q;
    prev_d    = prev_q;
    cr_d      = cr_q;
    fne_d     = fne_q;

    if (beat_i.valid && (beat_i.op == csv_tok_pkg::OP_END)) begin
      if (fne_q && row_vis) begin
        rr.kind   = csv_tok_pkg::KIND_FIELD_END;
        rr.last   = 1'b0;
        res_o[0]  = rr;
        res_cnt_o = 2'd1;
      end
      rr.kind = csv_tok_pkg::KIND_SUMMARY;
      rr.ch   = '0;
      rr.row  = end_diff[csv_tok_pkg::ROWIX_W-1:0];
      rr.col  = hi_ext[csv_tok_pkg::COLIX_W-1:0];
      rr.last = 1'b1;
      if (res_cnt_o == 2'd0) begin
        res_o[0] = rr;
      end else begin
        res_o[1] = rr;
      end
      res_cnt_o = res_cnt_o + 2'd1;
      row_d  = '0;
      col_d  = '0;
      hi_d   = '0;
      prev_d = 1'b0;
      cr_d   = 1'b0;
      fne_d  = 1'b0;
    end else if (beat_i.valid) begin
      if (!char_en) begin
        // A carriage return is swallowed unless it directly follows a swallowed one.
        cr_d = 1'b1;
      end else begin
        cr_d = 1'b0;
        if (act_append) begin
          rr.kind = csv_tok_pkg::KIND_CHAR;
          rr.ch   = beat_i.ch;
          fne_d   = 1'b1;
        end else if (act_close) begin
          rr.kind = csv_tok_pkg::KIND_FIELD_END;
          fne_d   = 1'b0;
        end else if (act_discard) begin
          rr.kind = csv_tok_pkg::KIND_DISCARD;
          fne_d   = 1'b0;
        end
        if ((act_append || act_close || act_discard) && row_vis) begin
          res_o[0]  = rr;
          res_cnt_o = 2'd1;
        end
        if (!is_d) begin
          prev_d = 1'b0;
        end
        if (act_adv) begin
          if (adv_nl) begin
            row_d = row_inc;
            col_d = '0;
          end else begin
            if (!merge_q || !prev_q) begin
              col_d = col_inc;
            end
            prev_d = 1'b1;
          end
        end
        hi_d = (col_d > hi_q) ? col_d : hi_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= csv_tok_pkg::ST_START;
      row_q  <= '0;
      col_q  <= '0;
      hi_q   <= '0;
      prev_q <= 1'b0;
      cr_q   <= 1'b0;
      fne_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      row_q  <= row_d;
      col_q  <= col_d;
      hi_q   <= hi_d;
      prev_q <= prev_d;
      cr_q   <= cr_d;
      fne_q  <= fne_d;
    end
  end

  // A character beat never yields more than one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i.valid && (beat_i.op == csv_tok_pkg::OP_CHAR)) |-> (res_cnt_o <= 2'd1))
    else $error("character beat produced two results");

  // End of input always returns the parser to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i.valid && (beat_i.op == csv_tok_pkg::OP_END)) |=>
      (st_q == csv_tok_pkg::ST_START) && (row_q == '0) && (hi_q == '0) && !fne_q)
    else $error("parser not cleared after end of input");

  // The highest column never trails the current column.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hi_q >= col_q)
    else $error("highest column below current column");

endmodule

FILE: hw/rtl/csv_tok_outq.sv
// ----------------------------------------------------------------------------
// CSV tokenizer output queue
// Small result queue that takes up to two results a cycle and hands out one
// beat a cycle on the master side whenever that side is ready.
// ----------------------------------------------------------------------------
module csv_tok_outq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  csv_tok_pkg::res_t [1:0] res_i,
  input  logic [1:0]              res_cnt_i,
  output logic                    space_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output csv_tok_pkg::res_t       res_o
);

  localparam int unsigned Depth = csv_tok_pkg::OUTQ_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  csv_tok_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];
  // Room for the two results of an end-of-input beat is always kept.
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign cnt_d   = cnt_q + CntW'(res_cnt_i) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (res_cnt_i != 2'd0) begin
      mem_q[wr_q] <= res_i[0];
    end
    if (res_cnt_i == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= res_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(res_cnt_i);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("output queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_i != 2'd0) |-> (cnt_q <= CntW'(Depth - 2)))
    else $error("results pushed without reserved space");

endmodule

FILE: hw/rtl/csv_field_tokenizer_top.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a stream of 16-bit characters into fields with row and column
// positions. A character beat is taken every cycle the queue has room; each
// beat's results are computed in the same cycle and queued for the master side.
// ----------------------------------------------------------------------------
// Rate: one input beat per clock cycle while the slave side is ready. A
// character beat yields zero or one result, an end-of-input beat one or two
// (a field end, then the summary). Results pass through a four-entry output
// queue; the slave side is ready whenever at least two entries are free, so
// with the master side ready the block sustains one character per cycle, and
// the results of a beat are written into the queue when the beat is accepted.
module csv_field_tokenizer_top #(
  parameter int unsigned ROW_LIMIT    = csv_tok_pkg::ROW_LIMIT_DEF,
  parameter int unsigned COLUMN_LIMIT = csv_tok_pkg::COLUMN_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Character stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] character
  input  logic        s_axis_tuser,   // [0] operation
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] character_res, [31:16] row_index,
                                      // [41:32] column_index, [47:42] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  csv_tok_pkg::in_beat_t  beat;
  csv_tok_pkg::cfg_wr_t   cfg;
  csv_tok_pkg::res_t [1:0] res;
  csv_tok_pkg::res_t      out_res;
  logic [1:0]             res_cnt;
  logic                   space;

  assign cfg_ready_o   = 1'b1;
  assign cfg.valid     = cfg_valid_i;
  assign cfg.index     = cfg_index_i;
  assign cfg.data      = cfg_data_i;

  assign s_axis_tready = space;
  assign beat.valid    = s_axis_tvalid && space;
  assign beat.op       = s_axis_tuser;
  assign beat.ch       = s_axis_tdata;

  csv_tok_parser #(
    .ROW_LIMIT    (ROW_LIMIT),
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .cfg_i     (cfg),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  csv_tok_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .res_cnt_i (res_cnt),
    .space_o   (space),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .res_o     (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.col, out_res.row, out_res.ch};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
